>>> src/snf_pkg.sv
package snf_pkg;

   // fixed point formats
   localparam int FREQ_FRAC_BITS  = 16;
   localparam int NOTE_WIDTH      = 8;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int TABLE_FRAC_BITS = 24;

   localparam int FREQ_W      = 32;
   localparam int RATIO_W     = RATIO_FRAC_BITS + 1;
   localparam int PROD_W      = FREQ_W + RATIO_W;
   localparam int EXP_W       = NOTE_WIDTH + 2;
   localparam int OCT_SHIFT_W = 5;
   localparam int SCALE_W     = 3;
   localparam int SEMI_W      = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_SELECT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_FREQUENCY = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVE_SHIFT   = 2'd2;

   // scale codes
   localparam logic [SCALE_W-1:0] SCALE_PENT_MAJOR = 3'd0;
   localparam logic [SCALE_W-1:0] SCALE_PENT_MINOR = 3'd1;
   localparam logic [SCALE_W-1:0] SCALE_BLUES      = 3'd2;
   localparam logic [SCALE_W-1:0] SCALE_MAJOR      = 3'd3;
   localparam logic [SCALE_W-1:0] SCALE_CHROMATIC  = 3'd4;
   localparam logic [SCALE_W-1:0] SCALE_WHOLE_TONE = 3'd5;

   // register reset values
   localparam logic [SCALE_W-1:0]     SCALE_SELECT_RESET   = SCALE_PENT_MAJOR;
   localparam logic [FREQ_W-1:0]      BASE_FREQUENCY_RESET = FREQ_W'(440) << FREQ_FRAC_BITS;
   localparam logic [OCT_SHIFT_W-1:0] OCTAVE_SHIFT_RESET   = '0;

   // floor division by scale size: offset to a positive value, reciprocal multiply
   localparam int DIV_U_W   = NOTE_WIDTH + 1;
   localparam int DIV_SHIFT = DIV_U_W + 4;
   localparam int NOTE_HALF = 2 ** (NOTE_WIDTH - 1);

   localparam int DIV_K5  = (NOTE_HALF + 4) / 5;
   localparam int DIV_K6  = (NOTE_HALF + 5) / 6;
   localparam int DIV_K7  = (NOTE_HALF + 6) / 7;
   localparam int DIV_K12 = (NOTE_HALF + 11) / 12;

   localparam int DIV_M5  = (2 ** DIV_SHIFT + 4) / 5;
   localparam int DIV_M6  = (2 ** DIV_SHIFT + 5) / 6;
   localparam int DIV_M7  = (2 ** DIV_SHIFT + 6) / 7;
   localparam int DIV_M12 = (2 ** DIV_SHIFT + 11) / 12;

   typedef struct packed {
      logic                         mute;
      logic [SEMI_W-1:0]            semitone;
      logic signed [NOTE_WIDTH-1:0] octave;
   } degree_type;

   // 2^(k/12) with 24 fraction bits
   function automatic logic [TABLE_FRAC_BITS:0] ratio_q24(input logic [SEMI_W-1:0] semi);
      logic [TABLE_FRAC_BITS:0] t;
      case (semi)
         4'd1:    t = 25'd17774841;
         4'd2:    t = 25'd18831788;
         4'd3:    t = 25'd19951585;
         4'd4:    t = 25'd21137968;
         4'd5:    t = 25'd22394897;
         4'd6:    t = 25'd23726566;
         4'd7:    t = 25'd25137421;
         4'd8:    t = 25'd26632170;
         4'd9:    t = 25'd28215802;
         4'd10:   t = 25'd29893600;
         4'd11:   t = 25'd31671166;
         default: t = 25'd16777216;
      endcase
      return t;
   endfunction

   // ratio rounded half up to the working fraction width
   function automatic logic [RATIO_W-1:0] ratio_value(input logic [SEMI_W-1:0] semi);
      logic [63:0] t;
      logic [63:0] r;
      t = 64'(ratio_q24(semi));
      if (RATIO_FRAC_BITS >= TABLE_FRAC_BITS) begin
         r = t << (RATIO_FRAC_BITS - TABLE_FRAC_BITS);
      end else begin
         r = (t + (64'd1 << (TABLE_FRAC_BITS - RATIO_FRAC_BITS - 1)))
             >> (TABLE_FRAC_BITS - RATIO_FRAC_BITS);
      end
      return r[RATIO_W-1:0];
   endfunction

endpackage

>>> src/snf_req_if.sv
interface snf_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [snf_pkg::NOTE_WIDTH-1:0] note_number;

   modport source (output valid, output note_number, input ready);
   modport sink   (input valid, input note_number, output ready);
endinterface

>>> src/snf_rsp_if.sv
interface snf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [snf_pkg::FREQ_W-1:0]    frequency;
   logic                          saturated;

   modport source (output valid, output frequency, output saturated, input ready);
   modport sink   (input valid, input frequency, input saturated, output ready);
endinterface

>>> src/scale_note_to_frequency_core.sv
// scale note to frequency core
//
// req_bus carries a signed scale-degree note; rsp_bus returns the pitch in
// unsigned fixed point (16 fraction bits) and a flag set when the octave
// shift overflowed and the pitch was clamped to all ones.
// scale, root frequency and octave offset come from the csr write port; the user
// must change them only while no request is in flight, the block does not enforce it.
// pipeline: degree split, then the table lookup and root times ratio multiply,
// then the octave shift and clamp into the result register.
// throughput is one request per cycle while the receiver takes results, set by the
// single 32 x 17 multiplier stage; every stage hands on whenever the one after it is free.
// when the receiver stalls, the result holds and the stages behind it fill;
// req_bus.ready drops once all three stages hold a request.
// reset empties the pipeline and loads the register defaults
// (major pentatonic, 440 Hz, no octave offset).
module scale_note_to_frequency_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [snf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [snf_pkg::CSR_DATA_W-1:0]    csr_write_data,
   snf_req_if.sink                           req_bus,
   snf_rsp_if.source                         rsp_bus
);

   // configuration registers
   logic [snf_pkg::SCALE_W-1:0]            scale_select_ff;
   logic [snf_pkg::FREQ_W-1:0]             base_frequency_ff;
   logic signed [snf_pkg::OCT_SHIFT_W-1:0] octave_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_select_ff   <= snf_pkg::SCALE_SELECT_RESET;
         base_frequency_ff <= snf_pkg::BASE_FREQUENCY_RESET;
         octave_shift_ff   <= snf_pkg::OCTAVE_SHIFT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            snf_pkg::CSR_SCALE_SELECT:   scale_select_ff   <= csr_write_data[snf_pkg::SCALE_W-1:0];
            snf_pkg::CSR_BASE_FREQUENCY: base_frequency_ff <= csr_write_data[snf_pkg::FREQ_W-1:0];
            snf_pkg::CSR_OCTAVE_SHIFT:   octave_shift_ff   <= csr_write_data[snf_pkg::OCT_SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage handshake: a stage takes new data when empty or emptying
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_free, s2_free, s3_free;
   logic req_accept;

   assign s3_free    = !rsp_valid_ff || rsp_bus.ready;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_accept = req_bus.valid && s1_free;

   assign req_bus.ready = s1_free;

   // stage 1: degree, semitone and octave of the note
   snf_pkg::degree_type s1_degree_in, s1_degree_ff;

   snf_degree u_degree (
      .note_number  (req_bus.note_number),
      .scale_select (scale_select_ff),
      .degree       (s1_degree_in)
   );

   // stage 2: root times ratio, total binary exponent
   logic [snf_pkg::PROD_W-1:0]       s2_product_in, s2_product_ff;
   logic signed [snf_pkg::EXP_W-1:0] s2_exponent_in, s2_exponent_ff;
   logic                             s2_mute_ff;

   always_comb begin
      s2_product_in  = snf_pkg::PROD_W'(base_frequency_ff)
                     * snf_pkg::PROD_W'(snf_pkg::ratio_value(s1_degree_ff.semitone));
      s2_exponent_in = snf_pkg::EXP_W'(octave_shift_ff)
                     + snf_pkg::EXP_W'($signed(s1_degree_ff.octave))
                     - snf_pkg::EXP_W'(snf_pkg::RATIO_FRAC_BITS);
   end

   // stage 3: octave shift with clamp
   logic [snf_pkg::FREQ_W-1:0] rsp_frequency_in, rsp_frequency_ff;
   logic                       rsp_saturated_in, rsp_saturated_ff;

   snf_octave_shift u_octave_shift (
      .product   (s2_product_ff),
      .exponent  (s2_exponent_ff),
      .mute      (s2_mute_ff),
      .frequency (rsp_frequency_in),
      .saturated (rsp_saturated_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload, held while the next stage is busy
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_degree_ff <= s1_degree_in;
      end
      if (s2_free && s1_valid_ff) begin
         s2_product_ff  <= s2_product_in;
         s2_exponent_ff <= s2_exponent_in;
         s2_mute_ff     <= s1_degree_ff.mute;
      end
      if (s3_free && s2_valid_ff) begin
         rsp_frequency_ff <= rsp_frequency_in;
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.frequency = rsp_frequency_ff;
   assign rsp_bus.saturated = rsp_saturated_ff;

   // checks
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not enter stage 1");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_free |=> s2_valid_ff && $stable(s2_product_ff)
                                   && $stable(s2_exponent_ff))
      else $error("stage 2 changed while stalled");

   a_mute_zero: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_mute_ff && s3_free
         |=> rsp_bus.valid && rsp_bus.frequency == '0 && !rsp_bus.saturated)
      else $error("unused scale gave a nonzero result");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.saturated |-> rsp_bus.frequency == '1)
      else $error("saturated result not clamped");

endmodule

>>> src/snf_degree.sv
module snf_degree (
   input  logic signed [snf_pkg::NOTE_WIDTH-1:0] note_number,
   input  logic [snf_pkg::SCALE_W-1:0]           scale_select,
   output snf_pkg::degree_type                   degree
);

   typedef struct packed {
      logic [snf_pkg::SEMI_W-1:0]            rem;
      logic signed [snf_pkg::NOTE_WIDTH-1:0] quot;
   } divmod_type;

   localparam int UW = snf_pkg::DIV_U_W;
   localparam int SW = snf_pkg::DIV_SHIFT;

   // floor division by a fixed divisor, all divisor terms are constants
   function automatic divmod_type floor_divmod(
      input logic signed [snf_pkg::NOTE_WIDTH-1:0] note,
      input logic [UW-1:0]                         d,
      input logic [UW-1:0]                         k,
      input logic [SW-1:0]                         m
   );
      logic [UW-1:0]    u;
      logic [UW+SW-1:0] prod;
      logic [UW-1:0]    qu;
      logic [UW-1:0]    rem;
      divmod_type       res;
      u    = UW'(note) + UW'(k * d);
      prod = (UW+SW)'(u) * (UW+SW)'(m);
      qu   = prod[SW +: UW];
      rem  = u - UW'(qu * d);
      res.rem  = rem[snf_pkg::SEMI_W-1:0];
      res.quot = snf_pkg::NOTE_WIDTH'(qu - k);
      return res;
   endfunction

   divmod_type div5, div6, div7, div12, sel;

   always_comb begin
      div5  = floor_divmod(note_number, UW'(5),  UW'(snf_pkg::DIV_K5),  SW'(snf_pkg::DIV_M5));
      div6  = floor_divmod(note_number, UW'(6),  UW'(snf_pkg::DIV_K6),  SW'(snf_pkg::DIV_M6));
      div7  = floor_divmod(note_number, UW'(7),  UW'(snf_pkg::DIV_K7),  SW'(snf_pkg::DIV_M7));
      div12 = floor_divmod(note_number, UW'(12), UW'(snf_pkg::DIV_K12), SW'(snf_pkg::DIV_M12));
   end

   always_comb begin
      degree = '0;
      sel    = div5;
      case (scale_select)
         snf_pkg::SCALE_PENT_MAJOR: begin
            sel = div5;
            case (sel.rem)
               4'd1:    degree.semitone = 4'd2;
               4'd2:    degree.semitone = 4'd4;
               4'd3:    degree.semitone = 4'd7;
               4'd4:    degree.semitone = 4'd9;
               default: degree.semitone = 4'd0;
            endcase
         end
         snf_pkg::SCALE_PENT_MINOR: begin
            sel = div5;
            case (sel.rem)
               4'd1:    degree.semitone = 4'd3;
               4'd2:    degree.semitone = 4'd5;
               4'd3:    degree.semitone = 4'd7;
               4'd4:    degree.semitone = 4'd10;
               default: degree.semitone = 4'd0;
            endcase
         end
         snf_pkg::SCALE_BLUES: begin
            sel = div6;
            case (sel.rem)
               4'd1:    degree.semitone = 4'd3;
               4'd2:    degree.semitone = 4'd5;
               4'd3:    degree.semitone = 4'd6;
               4'd4:    degree.semitone = 4'd7;
               4'd5:    degree.semitone = 4'd10;
               default: degree.semitone = 4'd0;
            endcase
         end
         snf_pkg::SCALE_MAJOR: begin
            sel = div7;
            case (sel.rem)
               4'd1:    degree.semitone = 4'd2;
               4'd2:    degree.semitone = 4'd4;
               4'd3:    degree.semitone = 4'd5;
               4'd4:    degree.semitone = 4'd7;
               4'd5:    degree.semitone = 4'd9;
               4'd6:    degree.semitone = 4'd11;
               default: degree.semitone = 4'd0;
            endcase
         end
         snf_pkg::SCALE_CHROMATIC: begin
            sel = div12;
            degree.semitone = sel.rem;
         end
         snf_pkg::SCALE_WHOLE_TONE: begin
            sel = div6;
            degree.semitone = {sel.rem[2:0], 1'b0};
         end
         default: begin
            degree.mute = 1'b1;
         end
      endcase
      degree.octave = sel.quot;
   end

endmodule

>>> src/snf_octave_shift.sv
module snf_octave_shift (
   input  logic [snf_pkg::PROD_W-1:0]       product,
   input  logic signed [snf_pkg::EXP_W-1:0] exponent,
   input  logic                             mute,
   output logic [snf_pkg::FREQ_W-1:0]       frequency,
   output logic                             saturated
);

   localparam int PW  = snf_pkg::PROD_W;
   localparam int FW  = snf_pkg::FREQ_W;
   localparam int LSW = $clog2(FW);
   localparam logic signed [snf_pkg::EXP_W-1:0] LEFT_LIMIT = snf_pkg::EXP_W'(FW);

   logic [snf_pkg::EXP_W-1:0] right_amount;
   logic [PW-1:0]             right_val;
   logic [PW+FW-1:0]          left_val;

   // shift amounts past the product width give zero
   assign right_amount = -exponent;
   assign right_val    = product >> right_amount;
   assign left_val     = (PW+FW)'(product) << exponent[LSW-1:0];

   always_comb begin
      frequency = '0;
      saturated = 1'b0;
      if (mute) begin
         frequency = '0;
      end else if (exponent <= 0) begin
         if (|right_val[PW-1:FW]) begin
            saturated = 1'b1;
         end else begin
            frequency = right_val[FW-1:0];
         end
      end else if (product == '0) begin
         frequency = '0;
      end else if (exponent >= LEFT_LIMIT) begin
         saturated = 1'b1;
      end else if (|left_val[PW+FW-1:FW]) begin
         saturated = 1'b1;
      end else begin
         frequency = left_val[FW-1:0];
      end
      if (saturated) begin
         frequency = '1;
      end
   end

endmodule
